// ===== rtl/shf_pkg.sv =====
// Shared types and constants for the 3x3 thresholded sharpening filter.
// No dependencies; every other file but shf_line_store imports this package.
package shf_pkg;

  // Defaults for the top-level parameters.
  localparam int MAX_COLS_DEF = 2048;
  localparam int MAX_CH_DEF   = 4;

  // Configuration port data width (widest register) and register reset values.
  localparam int CFG_W    = 16;
  localparam int ROWS_RST = 480;
  localparam int COLS_RST = 640;
  localparam int CH_RST   = 4;
  localparam int THR_RST  = 255;

  // Channel 3 carries alpha and bypasses the filter.
  localparam int ALPHA_LANE = 3;

  typedef logic [7:0] chan_t;

  typedef enum logic [1:0] {
    CFG_ROWS     = 2'd0,
    CFG_COLS     = 2'd1,
    CFG_CHANNELS = 2'd2,
    CFG_THRESH   = 2'd3
  } cfg_reg_t;

  // Neighborhood of one channel around the center pixel.
  typedef struct packed {
    chan_t center;
    chan_t up;
    chan_t down;
    chan_t left;
    chan_t right;
  } taps_t;

  // Per-lane control for one item.
  typedef struct packed {
    logic  border;
    logic  active;
    chan_t thr;
  } lane_ctrl_t;

  // Push request from the lanes' stage into the output queue.
  typedef struct packed {
    logic valid;
    logic last;
  } push_t;

  // One result beat.
  typedef struct packed {
    chan_t out_ch0;
    chan_t out_ch1;
    chan_t out_ch2;
    chan_t out_ch3;
    logic  frame_end;
  } beat_t;

endpackage

// ===== rtl/shf_if.sv =====
// Stream interfaces for pixel input beats and filtered result beats.
// Depends on shf_pkg for the channel type.
interface shf_pix_if import shf_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  action;
  chan_t in_ch0;
  chan_t in_ch1;
  chan_t in_ch2;
  chan_t in_ch3;

  modport source (output valid, action, in_ch0, in_ch1, in_ch2, in_ch3, input ready);
  modport sink   (input valid, action, in_ch0, in_ch1, in_ch2, in_ch3, output ready);
endinterface

interface shf_res_if import shf_pkg::*; ();
  logic  valid;
  logic  ready;
  chan_t out_ch0;
  chan_t out_ch1;
  chan_t out_ch2;
  chan_t out_ch3;
  logic  frame_end;

  modport source (output valid, out_ch0, out_ch1, out_ch2, out_ch3, frame_end, input ready);
  modport sink   (input valid, out_ch0, out_ch1, out_ch2, out_ch3, frame_end, output ready);
endinterface

// ===== rtl/shf_line_store.sv =====
// Paired line store (upper and middle line per column) with registered read,
// write-to-read bypass and a zeroing sweep after reset. Depends on nothing.
module shf_line_store #(
  parameter int DEPTH = 2048,
  parameter int WIDTH = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  output logic                     busy
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_raw;
  logic [WIDTH-1:0] byp_data;
  logic             byp_hit;
  logic [AW-1:0]    clr_addr;
  logic             mem_we;
  logic [AW-1:0]    mem_wa;
  logic [WIDTH-1:0] mem_wd;

  // Sweep zeros through every entry after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      if (clr_addr == AW'(DEPTH - 1)) begin
        busy <= 1'b0;
      end else begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  always_comb begin
    mem_we = busy | wr_en;
    mem_wa = busy ? clr_addr : wr_addr;
    mem_wd = busy ? '0 : wr_data;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rd_raw <= mem[rd_addr];
    end
  end

  // A read that collides with the same-edge write takes the new data.
  always_ff @(posedge clk) begin
    if (rst) begin
      byp_hit <= 1'b0;
    end else if (rd_en) begin
      byp_hit <= wr_en && (rd_addr == wr_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      byp_data <= wr_data;
    end
  end

  assign rd_data = byp_hit ? byp_data : rd_raw;

  a_no_read_in_sweep: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> !busy)
    else $error("line store read during clearing sweep");

endmodule

// ===== rtl/shf_lane.sv =====
// One channel lane: 5*center minus four neighbors, clamp, keep threshold,
// border copy and alpha bypass, registered. Depends on shf_pkg.
module shf_lane import shf_pkg::*; #(
  parameter int LANE = 0
) (
  input  logic       clk,
  input  logic       en,
  input  lane_ctrl_t ctrl,
  input  taps_t      taps,
  output chan_t      val
);

  localparam bit IS_ALPHA = (LANE == ALPHA_LANE);

  logic [10:0]       gain;
  logic [9:0]        nsum;
  logic signed [11:0] s;
  chan_t             clamped;
  chan_t             val_next;

  always_comb begin
    gain = {1'b0, taps.center, 2'b00} + {3'b000, taps.center};
    nsum = {2'b00, taps.up} + {2'b00, taps.down} + {2'b00, taps.left} + {2'b00, taps.right};
    s    = $signed({1'b0, gain}) - $signed({2'b00, nsum});
    if (s < 0) begin
      clamped = '0;
    end else if (s > 12'sd255) begin
      clamped = 8'hFF;
    end else begin
      clamped = s[7:0];
    end

    if (!ctrl.active) begin
      val_next = '0;
    end else if (IS_ALPHA || ctrl.border) begin
      val_next = taps.center;
    end else if (clamped > ctrl.thr) begin
      val_next = taps.center;
    end else begin
      val_next = clamped;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      val <= val_next;
    end
  end

endmodule

// ===== rtl/shf_merge.sv =====
// Merges the lane results into one result beat with frame_end and queues it
// in a two-entry output buffer. Depends on shf_pkg and shf_res_if.
module shf_merge import shf_pkg::*; #(
  parameter int NCH = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  push_t                  push,
  input  logic [NCH-1:0][7:0]    lane_val,
  output logic                   full,
  shf_res_if.source              res
);

  chan_t [3:0] padded;
  beat_t       beat;
  beat_t       q [2];
  logic        wp;
  logic        rp;
  logic [1:0]  count;
  logic        pop;

  for (genvar k = 0; k < 4; k++) begin : g_pad
    if (k < NCH) begin : g_used
      assign padded[k] = lane_val[k];
    end else begin : g_zero
      assign padded[k] = '0;
    end
  end

  always_comb begin
    beat.out_ch0   = padded[0];
    beat.out_ch1   = padded[1];
    beat.out_ch2   = padded[2];
    beat.out_ch3   = padded[3];
    beat.frame_end = push.last;
  end

  assign pop  = res.valid && res.ready;
  assign full = (count == 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= '0;
    end else begin
      if (push.valid) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      count <= count + {1'b0, push.valid} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      q[wp] <= beat;
    end
  end

  always_comb begin
    res.valid     = (count != 2'd0);
    res.out_ch0   = q[rp].out_ch0;
    res.out_ch1   = q[rp].out_ch1;
    res.out_ch2   = q[rp].out_ch2;
    res.out_ch3   = q[rp].out_ch3;
    res.frame_end = q[rp].frame_end;
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> !full)
    else $error("result pushed into a full output queue");

  a_push_shows: assert property (@(posedge clk) disable iff (rst)
    push.valid && !pop |=> res.valid)
    else $error("queued result beat not presented");

endmodule

// ===== rtl/sharpen_filter_3x3_thresholded_core.sv =====
// A result beat passes the line store read, window and lane registers into
// the output queue after the input beat that completes its 3x3 neighborhood
// (image_cols+1 beats behind its own pixel). Throughput: one input beat per
// cycle while the queue is not full; the line store has one read and one
// write port, both used by each accepted beat. After reset a sweep zeros the
// line store, during which no pixel beat is taken (config writes are). Reset
// is synchronous; it restores register defaults, empties pipeline and queue.
module sharpen_filter_3x3_thresholded_core import shf_pkg::*; #(
  parameter int MAX_COLS     = MAX_COLS_DEF,
  parameter int MAX_CHANNELS = MAX_CH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  shf_pix_if.sink           pixels,
  shf_res_if.source         results
);

  localparam int AW = $clog2(MAX_COLS);
  localparam int PW = 8 * MAX_CHANNELS;
  localparam int COLS_EFF_RST = (COLS_RST > MAX_COLS) ? MAX_COLS : COLS_RST;
  localparam int CH_EFF_RST   = (CH_RST > MAX_CHANNELS) ? MAX_CHANNELS : CH_RST;

  // Configuration, held in already-clamped form: last row / last column
  // index, channels in use, keep threshold.
  logic [15:0]   rows_last;
  logic [AW-1:0] cols_last;
  logic [2:0]    nch;
  chan_t         thr;
  logic [11:0]   cfg_cols;
  logic [15:0]   cfg_rows;
  logic [2:0]    cfg_ch;

  assign cfg_rows = cfg_data[15:0];
  assign cfg_cols = cfg_data[11:0];
  assign cfg_ch   = cfg_data[2:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_last <= 16'(ROWS_RST - 1);
      cols_last <= AW'(COLS_EFF_RST - 1);
      nch       <= 3'(CH_EFF_RST);
      thr       <= 8'(THR_RST);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_ROWS: begin
          rows_last <= (cfg_rows < 16'd3) ? 16'd2 : cfg_rows - 16'd1;
        end
        CFG_COLS: begin
          if (cfg_cols < 12'd3) begin
            cols_last <= AW'(2);
          end else if (32'(cfg_cols) > MAX_COLS) begin
            cols_last <= AW'(MAX_COLS - 1);
          end else begin
            cols_last <= AW'(cfg_cols - 12'd1);
          end
        end
        CFG_CHANNELS: begin
          if (cfg_ch == 3'd0) begin
            nch <= 3'd1;
          end else if (32'(cfg_ch) > MAX_CHANNELS) begin
            nch <= 3'(MAX_CHANNELS);
          end else begin
            nch <= cfg_ch;
          end
        end
        CFG_THRESH: begin
          thr <= cfg_data[7:0];
        end
        default: ;
      endcase
    end
  end

  // Pipeline control. One enable moves every stage; it drops only when the
  // output queue is full, so a waiting result does not stop the input side.
  logic q_full;
  logic line_busy;
  logic en;
  logic accept;

  assign en            = !q_full;
  assign pixels.ready  = en && !line_busy;
  assign accept        = pixels.valid && pixels.ready;

  // Raster position counters. Input position picks the line store column;
  // output position decides border and frame end. All of it is settled at
  // the accept edge so the next beat sees the frame-end restart at once.
  logic [15:0]   in_row;
  logic [AW-1:0] in_col;
  logic [15:0]   out_row;
  logic [AW-1:0] out_col;
  logic [15:0]   in_row_next;
  logic [AW-1:0] in_col_next;
  logic [15:0]   out_row_next;
  logic [AW-1:0] out_col_next;
  logic          emit_now;
  logic          border_now;
  logic          last_now;
  logic          out_row_end;
  logic          out_col_end;

  always_comb begin
    emit_now    = (in_row >= 16'd2) || (in_row == 16'd1 && in_col != '0);
    out_row_end = (out_row >= rows_last);
    out_col_end = (out_col >= cols_last);
    border_now  = (out_row == 16'd0) || out_row_end || (out_col == '0) || out_col_end;
    last_now    = out_row_end && out_col_end;

    // Advance the input position; the row count saturates.
    if (in_col >= cols_last) begin
      in_col_next = '0;
      in_row_next = (in_row != 16'hFFFF) ? in_row + 16'd1 : in_row;
    end else begin
      in_col_next = in_col + 1'b1;
      in_row_next = in_row;
    end

    out_row_next = out_row;
    out_col_next = out_col;
    if (emit_now) begin
      if (last_now) begin
        // Frame done: restart both positions.
        in_row_next  = '0;
        in_col_next  = '0;
        out_row_next = '0;
        out_col_next = '0;
      end else if (out_col_end) begin
        out_col_next = '0;
        out_row_next = out_row + 16'd1;
      end else begin
        out_col_next = out_col + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_row  <= '0;
      in_col  <= '0;
      out_row <= '0;
      out_col <= '0;
    end else if (accept) begin
      in_row  <= in_row_next;
      in_col  <= in_col_next;
      out_row <= out_row_next;
      out_col <= out_col_next;
    end
  end

  // Incoming pixel, packed channel k at bits 8k+7:8k; a drain beat is a
  // zero pixel.
  chan_t [3:0]   in_chs;
  logic [PW-1:0] px_in;

  assign in_chs = {pixels.in_ch3, pixels.in_ch2, pixels.in_ch1, pixels.in_ch0};

  always_comb begin
    px_in = '0;
    for (int k = 0; k < MAX_CHANNELS; k++) begin
      px_in[8*k +: 8] = pixels.action ? 8'h00 : in_chs[k];
    end
  end

  // Stage 1: line store read in flight.
  logic          p1_valid;
  logic          p1_emit;
  logic          p1_border;
  logic          p1_last;
  logic [PW-1:0] p1_px;
  logic [AW-1:0] p1_col;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (en) begin
      p1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p1_emit   <= emit_now;
      p1_border <= border_now;
      p1_last   <= last_now;
      p1_px     <= px_in;
      p1_col    <= in_col;
    end
  end

  // Line store entry: upper line over middle line at one column. Reading a
  // column returns the two rows above; writing moves middle to upper and the
  // new pixel into middle.
  logic [2*PW-1:0] rd_data;
  logic [PW-1:0]   rd_top;
  logic [PW-1:0]   rd_mid;
  logic            line_wr;

  assign rd_top  = rd_data[2*PW-1:PW];
  assign rd_mid  = rd_data[PW-1:0];
  assign line_wr = en && p1_valid;

  shf_line_store #(
    .DEPTH (MAX_COLS),
    .WIDTH (2 * PW)
  ) u_lines (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (in_col),
    .rd_data (rd_data),
    .wr_en   (line_wr),
    .wr_addr (p1_col),
    .wr_data ({rd_mid, p1_px}),
    .busy    (line_busy)
  );

  // 3x3 window. The right column takes the new (upper, middle, pixel)
  // column; the corners never feed the filter, so only the left middle is
  // kept of the left column.
  logic [PW-1:0] win_l_mid;
  logic [PW-1:0] win_c_top;
  logic [PW-1:0] win_c_mid;
  logic [PW-1:0] win_c_bot;
  logic [PW-1:0] win_r_top;
  logic [PW-1:0] win_r_mid;
  logic [PW-1:0] win_r_bot;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_l_mid <= '0;
      win_c_top <= '0;
      win_c_mid <= '0;
      win_c_bot <= '0;
      win_r_top <= '0;
      win_r_mid <= '0;
      win_r_bot <= '0;
    end else if (line_wr) begin
      win_l_mid <= win_c_mid;
      win_c_top <= win_r_top;
      win_c_mid <= win_r_mid;
      win_c_bot <= win_r_bot;
      win_r_top <= rd_top;
      win_r_mid <= rd_mid;
      win_r_bot <= p1_px;
    end
  end

  // Stage 2: window holds this item's neighborhood; lanes compute.
  logic p2_valid;
  logic p2_emit;
  logic p2_border;
  logic p2_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else if (en) begin
      p2_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_emit   <= p1_emit;
      p2_border <= p1_border;
      p2_last   <= p1_last;
    end
  end

  // One lane per channel, all working on the same item.
  logic [MAX_CHANNELS-1:0][7:0] lane_val;

  for (genvar k = 0; k < MAX_CHANNELS; k++) begin : g_lane
    taps_t      taps;
    lane_ctrl_t ctrl;

    assign taps.center = win_c_mid[8*k +: 8];
    assign taps.up     = win_c_top[8*k +: 8];
    assign taps.down   = win_c_bot[8*k +: 8];
    assign taps.left   = win_l_mid[8*k +: 8];
    assign taps.right  = win_r_mid[8*k +: 8];
    assign ctrl.border = p2_border;
    assign ctrl.active = (3'(k) < nch);
    assign ctrl.thr    = thr;

    shf_lane #(
      .LANE (k)
    ) u_lane (
      .clk  (clk),
      .en   (en),
      .ctrl (ctrl),
      .taps (taps),
      .val  (lane_val[k])
    );
  end

  // Stage 3: lane results ready; push emitting items into the output queue.
  logic  p3_valid;
  logic  p3_last;
  push_t push;

  always_ff @(posedge clk) begin
    if (rst) begin
      p3_valid <= 1'b0;
    end else if (en) begin
      p3_valid <= p2_valid && p2_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p3_last <= p2_last;
    end
  end

  assign push.valid = en && p3_valid;
  assign push.last  = p3_last;

  shf_merge #(
    .NCH (MAX_CHANNELS)
  ) u_merge (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .lane_val (lane_val),
    .full     (q_full),
    .res      (results)
  );

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    accept && emit_now && last_now |=>
      in_row == '0 && in_col == '0 && out_row == '0 && out_col == '0)
    else $error("positions not restarted after frame end");

  a_idle_in_sweep: assert property (@(posedge clk) disable iff (rst)
    line_busy |-> !p1_valid && !p2_valid && !p3_valid)
    else $error("item in flight during line store sweep");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    p3_valid && !en |=> p3_valid)
    else $error("stalled result dropped from the last stage");

endmodule

// ===== tb/testbench.sv =====
// Self-checking bench for the 3x3 thresholded sharpening filter core.
// Depends on shf_pkg and the shf_pix_if / shf_res_if stream interfaces;
// streams pixel frames and compares every result beat against a model.
module testbench;
  import shf_pkg::*;

  localparam int HALF_PERIOD = 6;
  localparam int RESET_CYCLES = 11;
  localparam int MAX_WAIT = 18;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_ITEMS = 150;
  localparam int unsigned CYCLE_LIMIT = 200_000;

  // Meaning of the action bit of a pixel beat.
  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_DRAIN = 1'b1;

  typedef logic [31:0] pix_t;  // channel k in bits 8k+7:8k

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_we;
  logic [1:0]       cfg_index;
  logic [CFG_W-1:0] cfg_data;

  shf_pix_if pix_if ();
  shf_res_if res_if ();

  sharpen_filter_3x3_thresholded_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pixels    (pix_if),
    .results   (res_if)
  );

  always #HALF_PERIOD clk = ~clk;

  // Filter model: registers as written (clamped where used), line stores,
  // window and the input/output raster positions.
  logic [15:0] rows_reg;
  logic [11:0] cols_reg;
  logic [2:0]  chan_reg;
  chan_t       thresh_reg;
  pix_t        line_above [MAX_COLS_DEF];
  pix_t        line_center [MAX_COLS_DEF];
  pix_t        nbhd [9];
  int unsigned in_row, in_col, out_row, out_col;
  bit          frame_done;

  beat_t       pending_beats [$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned items_sent = 0;
  int unsigned hold_left = 0;
  bit          pix_paced = 1'b1;
  bit          res_paced = 1'b1;
  pix_t        smooth_base = '0;

  function automatic int unsigned eff_cols();
    if (cols_reg < 12'd3) return 3;
    if (int'(cols_reg) > MAX_COLS_DEF) return MAX_COLS_DEF;
    return int'(cols_reg);
  endfunction

  function automatic int unsigned eff_rows();
    return (rows_reg < 16'd3) ? 3 : int'(rows_reg);
  endfunction

  function automatic void reset_filter_model();
    rows_reg = 16'(ROWS_RST);
    cols_reg = 12'(COLS_RST);
    chan_reg = 3'(CH_RST);
    thresh_reg = 8'(THR_RST);
    foreach (line_above[i]) begin
      line_above[i] = '0;
      line_center[i] = '0;
    end
    foreach (nbhd[i]) nbhd[i] = '0;
    in_row = 0;
    in_col = 0;
    out_row = 0;
    out_col = 0;
  endfunction

  // Advance the model by one accepted beat; queue the result beat it causes.
  function automatic void sharpen_step(logic act, pix_t data);
    int unsigned cols, rows, nch;
    pix_t        px, top, mid;
    logic        emit, border, last;
    int          s;
    chan_t       c;
    chan_t       lane [4];
    beat_t       b;
    cols = eff_cols();
    rows = eff_rows();
    nch = (chan_reg == 3'd0) ? 1 :
          ((int'(chan_reg) > MAX_CH_DEF) ? MAX_CH_DEF : int'(chan_reg));
    // A drain tick enters the window as an all-zero pixel.
    px = (act == ACT_DRAIN) ? '0 : data;
    top = '0;
    mid = '0;
    if (in_col < MAX_COLS_DEF) begin
      top = line_above[in_col];
      mid = line_center[in_col];
      line_above[in_col] = mid;
      line_center[in_col] = px;
    end
    for (int r = 0; r < 3; r++) begin
      nbhd[r*3] = nbhd[r*3+1];
      nbhd[r*3+1] = nbhd[r*3+2];
    end
    nbhd[2] = top;
    nbhd[5] = mid;
    nbhd[8] = px;

    // Output trails the input by one row plus one pixel.
    emit = in_row >= 2 || (in_row == 1 && in_col >= 1);
    if (in_col + 1 >= cols) begin
      in_col = 0;
      if (in_row < 16'hFFFF) in_row++;  // saturate, never wrap
    end else begin
      in_col++;
    end
    if (!emit) return;

    border = out_row == 0 || out_row + 1 >= rows || out_col == 0 || out_col + 1 >= cols;
    last = out_row + 1 >= rows && out_col + 1 >= cols;
    for (int k = 0; k < 4; k++) begin
      c = nbhd[4][8*k +: 8];
      lane[k] = '0;
      if (k < nch) begin
        if (k == ALPHA_LANE || border) begin
          lane[k] = c;
        end else begin
          s = 5 * int'(c) - int'(nbhd[1][8*k +: 8]) - int'(nbhd[7][8*k +: 8])
              - int'(nbhd[3][8*k +: 8]) - int'(nbhd[5][8*k +: 8]);
          if (s < 0) s = 0;
          if (s > 255) s = 255;
          lane[k] = (s > int'(thresh_reg)) ? c : chan_t'(s);
        end
      end
    end
    b.out_ch0 = lane[0];
    b.out_ch1 = lane[1];
    b.out_ch2 = lane[2];
    b.out_ch3 = lane[3];
    b.frame_end = last;
    pending_beats = {pending_beats, b};

    if (last) begin
      in_row = 0;
      in_col = 0;
      out_row = 0;
      out_col = 0;
      frame_done = 1'b1;
    end else if (out_col + 1 >= cols) begin
      out_col = 0;
      out_row++;
    end else begin
      out_col++;
    end
  endfunction

  // Half the pixels are uniform noise, half sit close to a per-frame base so
  // that the filter lands inside 0..255 and the threshold actually decides.
  function automatic pix_t pick_pixel();
    pix_t p;
    if ($urandom_range(0, 1) == 1) return $urandom;
    for (int k = 0; k < 4; k++) p[8*k +: 8] = smooth_base[8*k +: 8] + 8'($urandom_range(0, 15));
    return p;
  endfunction

  function automatic void flag_beat(string what, beat_t want, beat_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%s: want %h %h %h %h end %b, got %h %h %h %h end %b", what,
               want.out_ch0, want.out_ch1, want.out_ch2, want.out_ch3, want.frame_end,
               got.out_ch0, got.out_ch1, got.out_ch2, got.out_ch3, got.frame_end);
  endfunction

  // Write all four registers on consecutive edges. Call at a rising edge.
  task automatic configure(logic [15:0] rows, logic [15:0] cols, logic [15:0] nch,
                           logic [15:0] thr);
    cfg_we <= 1'b1;
    cfg_index <= CFG_ROWS;
    cfg_data <= rows;
    @(posedge clk);
    cfg_index <= CFG_COLS;
    cfg_data <= cols;
    @(posedge clk);
    cfg_index <= CFG_CHANNELS;
    cfg_data <= nch;
    @(posedge clk);
    cfg_index <= CFG_THRESH;
    cfg_data <= thr;
    @(posedge clk);
    cfg_we <= 1'b0;
    rows_reg = rows;
    cols_reg = cols[11:0];
    chan_reg = nch[2:0];
    thresh_reg = thr[7:0];
  endtask

  // Offer one beat after a random gap; return at the edge that takes it.
  task automatic send_beat(logic act, pix_t data);
    int gap;
    gap = pix_paced ? $urandom_range(0, MAX_WAIT) : 0;
    if (gap > 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_if.valid <= 1'b1;
    pix_if.action <= act;
    pix_if.in_ch0 <= data[7:0];
    pix_if.in_ch1 <= data[15:8];
    pix_if.in_ch2 <= data[23:16];
    pix_if.in_ch3 <= data[31:24];
    @(posedge clk);
    while (!pix_if.ready) @(posedge clk);
    sharpen_step(act, data);
    items_sent++;
  endtask

  task automatic send_pixels(int n);
    repeat (n) send_beat(ACT_PIXEL, pick_pixel());
  endtask

  // Feed pixels until the frame's last result is predicted. The noise share
  // drops drain ticks into the pixel rows and pixels into the flush tail.
  task automatic stream_frame(int noise_pct);
    logic act;
    frame_done = 1'b0;
    while (!frame_done) begin
      act = ($urandom_range(0, 99) < noise_pct) ? ACT_DRAIN : ACT_PIXEL;
      if (in_row >= eff_rows()) act = (act == ACT_DRAIN) ? ACT_PIXEL : ACT_DRAIN;
      send_beat(act, pick_pixel());
    end
  endtask

  // Drop valid, let every expected beat arrive, then let the pipe empty.
  task automatic wait_idle();
    pix_if.valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure_random();
    logic [15:0] rows, cols, nch, thr;
    rows = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 2)) :
                                         16'($urandom_range(3, 7));
    case ($urandom_range(0, 9))
      0:       cols = 16'($urandom_range(0, 2));
      1:       cols = 16'($urandom_range(13, 48));
      default: cols = 16'($urandom_range(3, 10));
    endcase
    // Junk above each register's width must be ignored.
    cols[15:12] = 4'($urandom_range(0, 15));
    nch = {13'($urandom), 3'($urandom_range(0, 7))};
    case ($urandom_range(0, 6))
      0:       thr = 16'd0;
      1:       thr = 16'd255;
      default: thr = 16'($urandom_range(0, 255));
    endcase
    thr[15:8] = 8'($urandom_range(0, 255));
    configure(rows, cols, nch, thr);
  endtask

  // Two 3x3 frames with out-of-range registers. The first pushes the center
  // to both clamp limits with the threshold wide open, then flushes with
  // drain ticks followed by pixels that only reach border outputs. The second
  // keeps one channel, threshold zero, and a drain tick right of center.
  task automatic test_directed_frames();
    pix_t frame_a [9] = '{32'hFFFF_FFFF, 32'h0000_FF00, 32'hA5A5_A5A5,
                          32'h0000_0000, 32'h5A80_00FF, 32'h0010_FF00,
                          32'h1234_5678, 32'h0010_0000, 32'hFFFF_FFFF};
    pix_t frame_b [9] = '{32'h0102_0304, 32'hFFFF_FF10, 32'h8000_0080,
                          32'h0000_0010, 32'hFF00_FF40, 32'hFFFF_FFFF,
                          32'h7F7F_7F7F, 32'h0000_0010, 32'h0000_00FF};
    wait_idle();
    configure(16'd2, 16'd2, 16'd7, 16'd255);
    foreach (frame_a[i]) send_beat(ACT_PIXEL, frame_a[i]);
    send_beat(ACT_DRAIN, 32'hFFFF_FFFF);
    send_beat(ACT_DRAIN, 32'h0000_0000);
    send_beat(ACT_PIXEL, 32'hDEAD_BEEF);
    send_beat(ACT_PIXEL, 32'h0000_0000);
    wait_idle();
    configure(16'd3, 16'hF003, 16'd0, 16'd0);
    foreach (frame_b[i]) send_beat((i == 5) ? ACT_DRAIN : ACT_PIXEL, frame_b[i]);
    repeat (4) send_beat(ACT_DRAIN, $urandom);
  endtask

  // Change the geometry halfway through a frame while the core is idle.
  task automatic test_config_mid_frame();
    // Row limit cut below the output row: the frame ends on the current row.
    wait_idle();
    smooth_base = $urandom;
    configure(16'hFFFF, 16'd3, 16'd4, 16'd100);
    send_pixels(20);
    wait_idle();
    configure(16'd3, 16'd3, 16'd4, 16'd100);
    stream_frame(0);
    // Narrower rows: both column counters sit past the new limit and wrap.
    wait_idle();
    configure(16'd6, 16'd8, 16'd3, 16'd128);
    send_pixels(21);
    wait_idle();
    configure(16'd6, 16'd4, 16'd3, 16'd128);
    stream_frame(0);
    // Wider rows mid-frame.
    wait_idle();
    configure(16'd5, 16'd3, 16'd2, 16'd60);
    send_pixels(7);
    wait_idle();
    configure(16'd5, 16'd5, 16'd2, 16'd60);
    stream_frame(0);
  endtask

  // Hold the result side off while pixels keep coming back to back, so the
  // core fills up and has to stall its input.
  task automatic test_result_backpressure();
    wait_idle();
    smooth_base = $urandom;
    configure(16'd8, 16'd16, 16'd4, 16'd200);
    pix_paced = 1'b0;
    hold_left <= HOLD_CYCLES;
    stream_frame(10);
    pix_paced = 1'b1;
  endtask

  // Small random frames, some interrupted by a geometry change.
  task automatic test_random_frames();
    int unsigned first_item;
    first_item = items_sent;
    while (items_sent - first_item < RANDOM_ITEMS) begin
      wait_idle();
      pix_paced = ($urandom_range(0, 4) != 0);
      res_paced = ($urandom_range(0, 4) != 0);
      smooth_base = $urandom;
      configure_random();
      if ($urandom_range(0, 4) == 0) begin
        send_pixels($urandom_range(1, 20));
        wait_idle();
        configure_random();
      end
      stream_frame(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 15));
    end
  endtask

  // Result side: draw a stall per beat, and stay low while a hold runs.
  initial begin : result_pacing
    int gap;
    res_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      gap = res_paced ? $urandom_range(0, MAX_WAIT) : 0;
      if (gap > 0 || hold_left != 0) begin
        res_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
        while (hold_left != 0) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      @(posedge clk);
      while (!res_if.valid) @(posedge clk);
    end
  end

  // Count the hold-off down one cycle at a time.
  always @(posedge clk) begin
    if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // Compare each accepted result beat with the oldest prediction.
  always @(posedge clk) begin : result_check
    beat_t got, want;
    if (!rst && res_if.valid && res_if.ready) begin
      got.out_ch0 = res_if.out_ch0;
      got.out_ch1 = res_if.out_ch1;
      got.out_ch2 = res_if.out_ch2;
      got.out_ch3 = res_if.out_ch3;
      got.frame_end = res_if.frame_end;
      if (pending_beats.size() == 0) begin
        flag_beat("result beat with none pending", '0, got);
      end else begin
        want = pending_beats.pop_front();
        if (got.out_ch0 !== want.out_ch0 || got.out_ch1 !== want.out_ch1 ||
            got.out_ch2 !== want.out_ch2 || got.out_ch3 !== want.out_ch3 ||
            got.frame_end !== want.frame_end) begin
          flag_beat("result mismatch", want, got);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= CFG_ROWS;
    cfg_data <= '0;
    pix_if.valid <= 1'b0;
    pix_if.action <= ACT_PIXEL;
    pix_if.in_ch0 <= '0;
    pix_if.in_ch1 <= '0;
    pix_if.in_ch2 <= '0;
    pix_if.in_ch3 <= '0;
    reset_filter_model();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_directed_frames();
    test_config_mid_frame();
    test_result_backpressure();
    test_random_frames();
    wait_idle();

    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
